### rtl/core/lbpe_pkg.sv
// Shared constants, types and the prefix table for the line buffer echo block.
// No dependencies; imported by lbpe_ctrl, lbpe_dp, the top level and the testbench.
package lbpe_pkg;

  localparam int unsigned LINE_DEPTH = 32;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PFX_W      = 2;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [ADDR_W-1:0] FILL_MAX     = ADDR_W'(LINE_DEPTH - 1);
  localparam logic [PFX_W-1:0]  PFX_LAST     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;        // write rx byte at fill index, bump fill
    logic clr_fill;     // empty the line store
    logic load_prefix;  // load next prefix byte into the output register
    logic load_line;    // load next stored byte into the output register
  } lbpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_newline;   // incoming byte is a newline
    logic fill_full;    // store holds LINE_DEPTH-1 bytes
    logic prefix_last;  // prefix index at final prefix byte
    logic line_last;    // read pointer at final stored byte
    logic out_load;     // output register free or being drained
  } lbpe_sts_t;

  // "RX: "
  function automatic logic [BYTE_W-1:0] prefix_byte(input logic [PFX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      2'd0:    b = 8'h52;
      2'd1:    b = 8'h58;
      2'd2:    b = 8'h3A;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/lbpe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lbpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lbpe_ctrl.sv
// Controller FSM for the line buffer echo: idle, prefix replay, line replay.
// Depends on lbpe_pkg.
module lbpe_ctrl
  import lbpe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lbpe_sts_t sts_i,
  output lbpe_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREFIX = 2'd1;
  localparam logic [1:0] ST_LINE   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (sts_i.fill_full) begin
            cmd_o.clr_fill = 1'b1;
          end else begin
            cmd_o.store = 1'b1;
            if (sts_i.in_newline) begin
              state_d = ST_PREFIX;
            end
          end
        end
      end
      ST_PREFIX: begin
        if (sts_i.out_load) begin
          cmd_o.load_prefix = 1'b1;
          if (sts_i.prefix_last) begin
            state_d = ST_LINE;
          end
        end
      end
      ST_LINE: begin
        if (sts_i.out_load) begin
          cmd_o.load_line = 1'b1;
          if (sts_i.line_last) begin
            cmd_o.clr_fill = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/lbpe_dp.sv
// Datapath: fill counter, line store RAM, prefix index, read pointer, output register.
// Depends on lbpe_pkg and lbpe_ram.
module lbpe_dp
  import lbpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  lbpe_cmd_t         cmd_i,
  output lbpe_sts_t         sts_o,
  output logic              tx_valid_o,
  input  logic              tx_stall_i,
  output logic [BYTE_W-1:0] tx_byte_o,
  output logic              last_of_line_o
);

  logic [ADDR_W-1:0] fill_q, fill_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [PFX_W-1:0]  pidx_q, pidx_d;
  logic              tx_valid_q, tx_valid_d;
  logic [BYTE_W-1:0] tx_byte_q, tx_byte_d;
  logic              last_q, last_d;
  logic [BYTE_W-1:0] rd_data;
  logic [ADDR_W:0]   ptr_inc;

  // RAM read address is the next pointer, so rd_data tracks line_store[ptr_q].
  lbpe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (fill_q),
    .wdata_i (rx_byte_i),
    .raddr_i (ptr_d),
    .rdata_o (rd_data)
  );

  assign ptr_inc = {1'b0, ptr_q} + (ADDR_W+1)'(1);

  assign sts_o.in_newline  = (rx_byte_i == NEWLINE_BYTE);
  assign sts_o.fill_full   = (fill_q == FILL_MAX);
  assign sts_o.prefix_last = (pidx_q == PFX_LAST);
  assign sts_o.line_last   = (ptr_inc == {1'b0, fill_q});
  assign sts_o.out_load    = !tx_valid_q || !tx_stall_i;

  always_comb begin
    fill_d     = fill_q;
    ptr_d      = ptr_q;
    pidx_d     = pidx_q;
    tx_byte_d  = tx_byte_q;
    last_d     = last_q;
    tx_valid_d = tx_valid_q && tx_stall_i;

    if (cmd_i.clr_fill) begin
      fill_d = '0;
    end else if (cmd_i.store) begin
      fill_d = fill_q + ADDR_W'(1);
    end

    if (cmd_i.load_prefix) begin
      tx_byte_d  = prefix_byte(pidx_q);
      last_d     = 1'b0;
      tx_valid_d = 1'b1;
      pidx_d     = pidx_q + PFX_W'(1);
    end

    if (cmd_i.load_line) begin
      tx_byte_d  = rd_data;
      last_d     = sts_o.line_last;
      tx_valid_d = 1'b1;
      ptr_d      = sts_o.line_last ? '0 : ptr_inc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      ptr_q      <= '0;
      pidx_q     <= '0;
      tx_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      ptr_q      <= ptr_d;
      pidx_q     <= pidx_d;
      tx_valid_q <= tx_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_byte_q <= tx_byte_d;
    last_q    <= last_d;
  end

  assign tx_valid_o     = tx_valid_q;
  assign tx_byte_o      = tx_byte_q;
  assign last_of_line_o = last_q;

`ifndef SYNTHESIS
  // The line always ends on the stored newline.
  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_q && last_q |-> tx_byte_q == NEWLINE_BYTE)
    else $error("last_of_line on a byte other than newline");

  // Replay never reads past the stored bytes.
  a_read_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_line |-> ptr_q < fill_q)
    else $error("line replay read beyond fill count");

  // Pointer and prefix index are rewound whenever a byte is stored.
  a_rewound_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> ptr_q == '0 && pidx_q == '0)
    else $error("replay pointers not rewound at store");
`endif

endmodule

### rtl/core/line_buffer_prefix_echo_top.sv
// Top level of the line buffer with prefixed echo.
// Depends on lbpe_pkg, lbpe_ctrl, lbpe_dp (which holds lbpe_ram).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | input     | in_valid_i/in_stall_o | rx_byte_i[7:0]
//   tx      | output    | tx_valid_o/tx_stall_i | tx_byte_o[7:0], last_of_line_o
//
// A non-newline request (or a dropped one when the store is full) is taken
// while the controller stays idle. A newline request is stored, then the
// prefix "RX: " and the stored line, ending on its newline, are echoed.
// Reset (rst_ni low, asynchronous) empties the store count and the output
// register; the RAM contents are not cleared and need no clearing pass.
// tx_stall_i holds the output register; the replay simply waits, and in_stall_o
// stays high until the last byte of the line is loaded into the output register.
module line_buffer_prefix_echo_top
  import lbpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              tx_valid_o,
  input  logic              tx_stall_i,
  output logic [BYTE_W-1:0] tx_byte_o,
  output logic              last_of_line_o
);

  lbpe_cmd_t cmd;
  lbpe_sts_t sts;

  // Sequencer: decides store / drop / prefix replay / line replay.
  lbpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, counters and the output register.
  lbpe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .tx_valid_o     (tx_valid_o),
    .tx_stall_i     (tx_stall_i),
    .tx_byte_o      (tx_byte_o),
    .last_of_line_o (last_of_line_o)
  );

endmodule

### dv/tb_line_buffer_prefix_echo_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_buffer_prefix_echo_top: random bytes and lines in,
// echoed "RX: " lines checked against a cycle-free prediction of the line store.
// Depends on lbpe_pkg and the RTL under rtl/core.
module tb_line_buffer_prefix_echo_top;
  import lbpe_pkg::*;

  localparam int CLK_HALF     = 6;          // 12 ns period
  localparam int RESET_CYCLES = 12;
  localparam int ITEM_TARGET  = 330;        // requests offered in total, roughly
  localparam int GAP_MAX      = 19;         // longest per-request idle on either side
  localparam int HOLD_CYCLES  = 400;        // long receiver hold-off under pressure
  localparam int DRAIN_CYCLES = 40;         // longest echo plus margin
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int REPORT_MAX   = 10;

  // One echoed byte as it should leave the block.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } echo_beat_t;

  // Line store prediction plus the queue of echo bytes still owed by the block.
  class line_echo_model;
    logic [BYTE_W-1:0] line_bytes [LINE_DEPTH];
    int                fill;
    echo_beat_t        echo_q [$];
    int                bad_count;
    string             echo_prefix;

    function new();
      fill        = 0;
      bad_count   = 0;
      echo_prefix = "RX: ";
    endfunction

    // Accepted input request: store, drop on full, queue the echo on newline.
    function void take_rx(logic [BYTE_W-1:0] b);
      echo_beat_t beat;
      if (fill >= int'(FILL_MAX)) begin
        fill = 0;
        return;
      end
      line_bytes[fill] = b;
      fill++;
      if (b != NEWLINE_BYTE) return;
      for (int k = 0; k < echo_prefix.len(); k++) begin
        beat.data = echo_prefix[k];
        beat.last = 1'b0;
        echo_q.push_back(beat);
      end
      for (int k = 0; k < fill; k++) begin
        beat.data = line_bytes[k];
        beat.last = (k == fill - 1);
        echo_q.push_back(beat);
      end
      fill = 0;
    endfunction

    // Accepted output request: compare with the oldest expected byte.
    function void check_tx(logic [BYTE_W-1:0] data, logic last);
      echo_beat_t exp_beat;
      if (echo_q.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_MAX)
          $display("%0t: unexpected echo byte %02h last=%b", $realtime, data, last);
        return;
      end
      exp_beat = echo_q.pop_front();
      if (exp_beat.data !== data || exp_beat.last !== last) begin
        bad_count++;
        if (bad_count <= REPORT_MAX)
          $display("%0t: echo mismatch: expected byte %02h last=%b, got byte %02h last=%b",
                   $realtime, exp_beat.data, exp_beat.last, data, last);
      end
    endfunction

    function int pending();
      return echo_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [BYTE_W-1:0] rx_byte_i;
  logic              tx_valid_o;
  logic              tx_stall_i;
  logic [BYTE_W-1:0] tx_byte_o;
  logic              last_of_line_o;

  line_echo_model model;
  int             sent_count;
  int             rx_gap_max;    // sender idle bound for the current line
  int             tx_gap_max;    // receiver stall bound for the current line
  int             hold_len;      // nonzero asks the receiver for one long hold-off
  int             cycle_count;

  line_buffer_prefix_echo_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .tx_valid_o     (tx_valid_o),
    .tx_stall_i     (tx_stall_i),
    .tx_byte_o      (tx_byte_o),
    .last_of_line_o (last_of_line_o)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_HALF);
    clk_i = 1'b1;
    #(CLK_HALF);
  end

  // Watchdog: a hung handshake or a missing echo ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_line_buffer_prefix_echo_top: FAIL");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge; stimulus only moves on the
  // falling edge, so the values seen here are stable.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) model.take_rx(rx_byte_i);
      if (tx_valid_o && !tx_stall_i) model.check_tx(tx_byte_o, last_of_line_o);
    end
  end

  // Receiver: per echoed byte, stall a random number of cycles, then take it.
  // A hold-off request keeps stall high for the hold-off length in hold_len, counted right here.
  initial begin
    int gap;
    tx_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_len != 0) begin
        tx_stall_i = 1'b1;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end
      gap = $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
        tx_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      tx_stall_i = 1'b0;
      do @(posedge clk_i); while (!tx_valid_o && hold_len == 0);
      @(negedge clk_i);
    end
  end

  // One input request: optional idle gap, then hold valid until accepted.
  // Valid stays high across back-to-back requests, so it never toggles in a step.
  task automatic send_rx(input logic [BYTE_W-1:0] b);
    int gap;
    gap = $urandom_range(0, rx_gap_max);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_count++;
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == NEWLINE_BYTE);
    return b;
  endfunction

  // body_len non-newline bytes, then an optional newline.
  task automatic send_line(input int body_len, input bit with_newline);
    for (int i = 0; i < body_len; i++) send_rx(plain_byte());
    if (with_newline) send_rx(NEWLINE_BYTE);
  endtask

  // Fill the store to the brim, then one byte that gets dropped and empties it.
  task automatic send_overflow(input bit drop_newline);
    send_line(int'(FILL_MAX), 1'b0);
    send_rx(drop_newline ? NEWLINE_BYTE : plain_byte());
  endtask

  // Idle profile per line: mixed, none at all, or only one side idling.
  task automatic pick_idle();
    case ($urandom_range(0, 3))
      0: begin rx_gap_max = GAP_MAX; tx_gap_max = GAP_MAX; end
      1: begin rx_gap_max = 0;       tx_gap_max = 0;       end
      2: begin rx_gap_max = 0;       tx_gap_max = GAP_MAX; end
      default: begin rx_gap_max = GAP_MAX; tx_gap_max = 0; end
    endcase
  endtask

  initial begin
    bit pressed;
    int kind;
    int n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    sent_count  = 0;
    cycle_count = 0;
    hold_len    = 0;
    rx_gap_max  = 0;
    tx_gap_max  = 0;
    pressed     = 1'b0;
    model       = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: bare newline, then a line of extreme and zero bytes (every bit
    // both ways) at full rate, then one more line with idling on both sides.
    send_rx(NEWLINE_BYTE);
    send_rx(8'h00); send_rx(8'hFF); send_rx(8'h80); send_rx(8'h7F);
    send_rx(8'h55); send_rx(8'hAA); send_rx(8'h00); send_rx(NEWLINE_BYTE);
    rx_gap_max = GAP_MAX;
    tx_gap_max = GAP_MAX;
    send_rx(8'h0B); send_rx(8'h09); send_rx(8'h01); send_rx(NEWLINE_BYTE);
    send_rx(NEWLINE_BYTE);

    // Longest line (fill reaches its limit on the newline), and both flavors
    // of a dropped byte on a full store, each followed by a line to prove
    // the store was emptied.
    pick_idle();
    send_line(int'(FILL_MAX) - 1, 1'b1);
    pick_idle();
    send_overflow(1'b1);
    send_line(3, 1'b1);
    pick_idle();
    send_overflow(1'b0);
    send_line(0, 1'b1);

    // Random lines, mostly well formed, with overflow runs and raw noise.
    while (sent_count < ITEM_TARGET) begin
      if (!pressed && sent_count >= ITEM_TARGET / 2) begin
        // Pressure: receiver holds off while requests keep coming back to back,
        // so the block fills its output and stalls its input.
        pressed    = 1'b1;
        rx_gap_max = 0;
        tx_gap_max = 0;
        hold_len   = HOLD_CYCLES;
        send_line(5, 1'b1);
        send_line(12, 1'b1);
        send_line(2, 1'b1);
      end
      pick_idle();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4: send_line($urandom_range(0, 6), 1'b1);
        5, 6:          send_line($urandom_range(7, int'(FILL_MAX) - 2), 1'b1);
        7:             send_line(int'(FILL_MAX) - 1, 1'b1);
        8:             send_overflow(1'($urandom_range(0, 1)));
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) send_rx(BYTE_W'($urandom_range(0, 255)));
        end
      endcase
    end
    in_valid_i = 1'b0;

    // Drain: wait for every expected byte, then allow for any stray output.
    while (model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (model.bad_count == 0 && model.pending() == 0) begin
      $display("tb_line_buffer_prefix_echo_top: PASS");
    end else begin
      $display("tb_line_buffer_prefix_echo_top: FAIL");
    end
    $finish;
  end

endmodule

### line_buffer_prefix_echo_top.f
rtl/core/lbpe_pkg.sv
rtl/core/lbpe_ram.sv
rtl/core/lbpe_ctrl.sv
rtl/core/lbpe_dp.sv
rtl/core/line_buffer_prefix_echo_top.sv
dv/tb_line_buffer_prefix_echo_top.sv
